// ===== sv/rcpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpq_pkg: shared types and constants
// Field widths, item kinds and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package rcpq_pkg;

  localparam int POS_W = 11;
  localparam int VAL_W = 32;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic clr;       // clearing pass, one node per cycle
    logic load;      // capture the accepted item
    logic upd_a;     // update phase A: finish right write, read left node
    logic upd_b;     // update phase B: write left node, read right node, climb
    logic q_run;     // query walk towards the root
    logic out_load;  // move the query result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // last node being cleared
    logic upd_more;  // l < r, update walk not finished
    logic q_done;    // query path fully read and folded in
  } sts_t;

endpackage

// ===== sv/rcpq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpq_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rcpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rcpq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpq_datapath: node store and index arithmetic
// Holds the tree walk indices, the node RAM, the clear sweep and the query
// accumulator.
// ----------------------------------------------------------------------------
module rcpq_datapath #(
  parameter int LEAVES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rcpq_pkg::cmd_t             cmd,
  output rcpq_pkg::sts_t             sts,
  input  logic [rcpq_pkg::POS_W-1:0] range_lo,
  input  logic [rcpq_pkg::POS_W-1:0] range_hi,
  input  logic [rcpq_pkg::VAL_W-1:0] update_value,
  input  logic [rcpq_pkg::POS_W-1:0] query_pos,
  output logic [rcpq_pkg::VAL_W-1:0] query_max
);

  import rcpq_pkg::*;

  localparam int DEPTH = 2 * LEAVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;                      // holds 2*LEAVES
  localparam int CW    = ((NW > POS_W) ? NW : POS_W) + 1;

  // walk registers
  logic [NW-1:0]    l;
  logic [NW-1:0]    r;
  logic [VAL_W-1:0] v;
  logic             lp;
  logic [AW-1:0]    la;
  logic             rp;
  logic [AW-1:0]    ra;
  logic [AW-1:0]    p;
  logic             qp;
  logic [VAL_W-1:0] best;
  logic [AW-1:0]    cc;

  // RAM ports
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  // range clamp
  logic [CW-1:0] lo_ext, hi_ext, lo_c, hi_c, leaves_c;
  logic          nonempty, q_in;
  logic [VAL_W-1:0] raised;

  always_comb begin
    leaves_c = CW'(LEAVES);
    lo_ext   = CW'(range_lo);
    hi_ext   = CW'(range_hi);
    lo_c     = (lo_ext == '0) ? CW'(1) : lo_ext;
    hi_c     = (hi_ext > leaves_c) ? leaves_c : hi_ext;
    nonempty = (lo_c <= hi_c);
    q_in     = (CW'(query_pos) != '0) && (CW'(query_pos) <= leaves_c);
    raised   = (rdata < v) ? v : rdata;
  end

  always_comb begin
    we    = 1'b0;
    waddr = ra;
    wdata = raised;
    re    = 1'b0;
    raddr = l[AW-1:0];
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = cc;
      wdata = '0;
    end else if (cmd.upd_a) begin
      we    = rp;
      waddr = ra;
      re    = (l < r) && l[0];
      raddr = l[AW-1:0];
    end else if (cmd.upd_b) begin
      we    = lp;
      waddr = la;
      re    = r[0];
      raddr = AW'(r - NW'(1));
    end else if (cmd.q_run) begin
      re    = (p != '0);
      raddr = p;
    end
  end

  rcpq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cc <= '0;
    end else if (cmd.clr) begin
      cc <= cc + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v    <= update_value;
      lp   <= 1'b0;
      rp   <= 1'b0;
      best <= '0;
      qp   <= 1'b0;
      if (nonempty) begin
        l <= NW'(lo_c + leaves_c - CW'(1));
        r <= NW'(hi_c + leaves_c);
      end else begin
        l <= '0;
        r <= '0;
      end
      p <= q_in ? AW'(CW'(query_pos) + leaves_c - CW'(1)) : '0;
    end else if (cmd.upd_a) begin
      rp <= 1'b0;
      lp <= (l < r) && l[0];
      la <= l[AW-1:0];
      if ((l < r) && l[0]) begin
        l <= l + NW'(1);
      end
    end else if (cmd.upd_b) begin
      lp <= 1'b0;
      rp <= r[0];
      ra <= AW'(r - NW'(1));
      l  <= l >> 1;
      r  <= r >> 1;
    end else if (cmd.q_run) begin
      qp <= (p != '0);
      p  <= p >> 1;
      if (qp && (rdata > best)) begin
        best <= rdata;
      end
    end
    if (cmd.out_load) begin
      query_max <= best;
    end
  end

  assign sts.clr_last = (cc == AW'(DEPTH - 1));
  assign sts.upd_more = (l < r);
  assign sts.q_done   = (p == '0) && !qp;

endmodule

// ===== sv/rcpq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpq_ctrl: sequencing state machine
// Clear sweep, update walk, query walk and the output handshake.
// ----------------------------------------------------------------------------
module rcpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           kind,
  output logic           out_valid,
  input  logic           out_ready,
  output rcpq_pkg::cmd_t cmd,
  input  rcpq_pkg::sts_t sts
);

  import rcpq_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_UA   = 3'd2;
  localparam logic [2:0] ST_UB   = 3'd3;
  localparam logic [2:0] ST_QRUN = 3'd4;
  localparam logic [2:0] ST_QOUT = 3'd5;

  logic [2:0] state, state_next;
  logic       accept, out_free;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = (kind == KIND_QUERY) ? ST_QRUN : ST_UA;
        end
      end
      ST_UA: begin
        cmd.upd_a  = 1'b1;
        state_next = sts.upd_more ? ST_UB : ST_IDLE;
      end
      ST_UB: begin
        cmd.upd_b  = 1'b1;
        state_next = ST_UA;
      end
      ST_QRUN: begin
        cmd.q_run = 1'b1;
        if (sts.q_done) state_next = ST_QOUT;
      end
      ST_QOUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/range_chmax_point_query_tree_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_chmax_point_query_tree_core: range raise, point max segment tree
// Bottom-up tree of 32-bit maxima over LEAVES positions in one node RAM.
// ----------------------------------------------------------------------------
// Update: each tree level walked takes a phase A and a phase B, and a final
//   phase A ends the walk; the read-modify-write shares the one read and one
//   write port of the node RAM. Updates give no result item.
// Query: one node read per level along the leaf-to-root path, then the result
//   is moved into the output register once no earlier result is still waiting.
// One item at a time; a waiting result does not hold off the next item.
// Reset: the node RAM is swept to zero with in_ready low.
module range_chmax_point_query_tree_core #(
  parameter int LEAVES = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic [rcpq_pkg::POS_W-1:0] range_lo,
  input  logic [rcpq_pkg::POS_W-1:0] range_hi,
  input  logic [rcpq_pkg::VAL_W-1:0] update_value,
  input  logic [rcpq_pkg::POS_W-1:0] query_pos,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rcpq_pkg::VAL_W-1:0] query_max
);

  import rcpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: clear sweep after reset, then one item at a time.
  // Updates alternate phase A (read left node) and phase B (write left,
  // read right, climb one level); the right write lands in the next A.
  rcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: clamps the range to the leaves, holds the walk indices,
  // node RAM and the query accumulator / output register.
  rcpq_datapath #(
    .LEAVES(LEAVES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .range_lo    (range_lo),
    .range_hi    (range_hi),
    .update_value(update_value),
    .query_pos   (query_pos),
    .query_max   (query_max)
  );

endmodule

// ===== sv/rcpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpq_checker: port-level assertions
// Watches the handshakes of the tree core; bound to the top level.
// ----------------------------------------------------------------------------
module rcpq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       kind,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rcpq_pkg::VAL_W-1:0] query_max
);

  import rcpq_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(query_max))
    else $error("result dropped or changed while stalled");

  // clear sweep runs straight after reset
  a_clear: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready)
    else $error("item taken during clear sweep");

  // one item at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // an update never raises a result
  a_upd_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_UPDATE) && !out_valid |=> !out_valid)
    else $error("result after an update");

endmodule

bind range_chmax_point_query_tree_core rcpq_checker u_rcpq_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .kind     (kind),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .query_max(query_max)
);
